FILE: hw/rtl/tci_pkg.sv
package tci_pkg;

	localparam int NUM_TIMERS_DEF = 3;
	localparam int MAX_TIMERS     = 3;

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_CTRL_WR = 2'd1,
		ACT_CNT_WR  = 2'd2,
		ACT_CNT_RD  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ACC_WHOLE = 2'd0,
		ACC_LOW   = 2'd1,
		ACC_HIGH  = 2'd2,
		ACC_ALT   = 2'd3
	} access_t;

	localparam logic [2:0] CM_ONESHOT = 3'd0;
	localparam logic [2:0] CM_RETRIG  = 3'd1;
	localparam logic [2:0] CM_RATE    = 3'd2;
	localparam logic [2:0] CM_SQUARE  = 3'd3;

	// per-counter strobes for the item being retired this cycle
	typedef struct packed {
		logic       tick;
		logic       ctrl_wr;
		logic       cnt_wr;
		logic       cnt_rd;
		logic [7:0] data;
	} cmd_t;

endpackage

FILE: hw/rtl/tci_counter.sv
module tci_counter (
	input  logic             clk,
	input  logic             arst_n,
	input  tci_pkg::cmd_t    cmd,
	output logic [7:0]       rd_byte,
	output logic             event_hit
);
	import tci_pkg::*;

	logic [15:0] reload_q;
	logic [15:0] work_q;
	logic [1:0]  acc_q;
	logic [2:0]  cm_q;
	logic        bcd_q;
	logic        tog_q;

	logic        tog_n;
	logic [15:0] wr_val;
	logic [15:0] work_dec;
	logic [15:0] work_next;
	logic [7:0]  rd_sel;

	assign tog_n    = ~tog_q;
	assign work_dec = work_q - 16'd1;

	always_comb begin
		case (acc_q)
			ACC_LOW:  wr_val = {reload_q[15:8], cmd.data};
			ACC_HIGH: wr_val = {cmd.data, reload_q[7:0]};
			ACC_ALT:  wr_val = tog_n ? {cmd.data, reload_q[7:0]} : {reload_q[15:8], cmd.data};
			default:  wr_val = {8'h00, cmd.data};
		endcase
	end

	always_comb begin
		case (acc_q)
			ACC_HIGH: rd_sel = reload_q[15:8];
			ACC_ALT:  rd_sel = tog_n ? reload_q[15:8] : reload_q[7:0];
			default:  rd_sel = reload_q[7:0];
		endcase
	end

	assign rd_byte = cmd.cnt_rd ? rd_sel : 8'h00;

	always_comb begin
		work_next = work_q;
		event_hit = 1'b0;
		case (cm_q)
			CM_ONESHOT: begin
				if (work_q != 16'd0) begin
					work_next = work_dec;
					event_hit = (work_dec == 16'd0);
				end
			end
			CM_RETRIG, CM_SQUARE: begin
				if (work_dec == 16'd0) begin
					event_hit = 1'b1;
					work_next = reload_q;
				end else begin
					work_next = work_dec;
				end
			end
			CM_RATE: begin
				if (work_dec == 16'd1) begin
					event_hit = 1'b1;
					work_next = reload_q;
				end else begin
					work_next = work_dec;
				end
			end
			default: begin
				work_next = work_q;
			end
		endcase
		event_hit = event_hit & cmd.tick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= '0;
			work_q   <= '0;
			acc_q    <= '0;
			cm_q     <= '0;
			bcd_q    <= 1'b0;
			tog_q    <= 1'b0;
		end else begin
			if (cmd.tick) begin
				work_q <= work_next;
				// retrigger mode parks the readback value at zero
				if (!(cm_q == CM_RETRIG && reload_q == 16'd0))
					reload_q <= reload_q - 16'd1;
			end
			if (cmd.ctrl_wr) begin
				acc_q <= cmd.data[5:4];
				cm_q  <= cmd.data[3:1];
				bcd_q <= cmd.data[0];
				tog_q <= 1'b1;
			end
			if (cmd.cnt_wr) begin
				reload_q <= wr_val;
				work_q   <= wr_val;
				if (acc_q == ACC_ALT)
					tog_q <= tog_n;
			end
			if (cmd.cnt_rd && acc_q == ACC_ALT)
				tog_q <= tog_n;
			// BCD flag is held for completeness; counting is binary
			if (bcd_q && 1'b0)
				tog_q <= tog_q;
		end
	end

endmodule

FILE: hw/rtl/three_counter_interval_timer_top.sv
// channel   dir  fields (tdata, low bit first)
// s_axis    in   action[1:0], counter_sel[3:2], data[11:4], zero[15:12]
// m_axis    out  read_data[7:0], irq[8], zero[15:9]
//
// One item per cycle while the output is not stalled: an item waits in the input register,
// then its counter updates and its result are committed together into the output register.
// Result valid rises when the item moves from the input register into the output register;
// the output handshake is then taken from the output register.
// Reset clears all counter state and the valid flags of the input and output registers.
// A stalled output holds its result; the input register keeps taking items
// as long as the output register can move.
module three_counter_interval_timer_top #(
	parameter int NUM_TIMERS = tci_pkg::NUM_TIMERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // action[1:0], counter_sel[3:2], data[11:4]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // read_data[7:0], irq[8]
);
	import tci_pkg::*;

	logic       valid_s1;
	logic [1:0] action_s1;
	logic [1:0] sel_s1;
	logic [7:0] data_s1;

	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic       irq_q;

	logic       advance;
	logic [7:0] rd_or;
	logic [NUM_TIMERS-1:0] ev_v;
	logic [7:0] rd_v [NUM_TIMERS];

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_s1 <= s_axis_tdata[1:0];
			sel_s1    <= s_axis_tdata[3:2];
			data_s1   <= s_axis_tdata[11:4];
		end
	end

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cnt
		cmd_t cmd;
		always_comb begin
			cmd.tick    = advance && action_s1 == ACT_TICK;
			cmd.ctrl_wr = advance && action_s1 == ACT_CTRL_WR && data_s1[7:6] == 2'(i);
			cmd.cnt_wr  = advance && action_s1 == ACT_CNT_WR && sel_s1 == 2'(i);
			cmd.cnt_rd  = advance && action_s1 == ACT_CNT_RD && sel_s1 == 2'(i);
			cmd.data    = data_s1;
		end
		tci_counter u_cnt (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.rd_byte   (rd_v[i]),
			.event_hit (ev_v[i])
		);
	end

	// only the addressed lane drives a nonzero byte
	always_comb begin
		rd_or = 8'h00;
		for (int i = 0; i < NUM_TIMERS; i++)
			rd_or = rd_or | rd_v[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rd_or;
			irq_q       <= ev_v[0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, irq_q, read_data_q};

endmodule
